// ----- design/rfst_pkg.sv -----
// Shared constants, command codes and sequencer states of the range flip segment tree.
package rfst_pkg;

   localparam int SIZE_DEFAULT = 1024;
   localparam int N_USED_RESET = 1024;

   // field widths
   localparam int POS_W   = 11;
   localparam int QIDX_W  = 10;
   localparam int TOTAL_W = 11;

   // command codes
   localparam logic CMD_FLIP  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_AP_RD,
      ST_AP_WR,
      ST_FX_L,
      ST_FX_R,
      ST_FX_S,
      ST_FX_W,
      ST_Q_RD,
      ST_Q_CK,
      ST_DONE
   } state_type;

endpackage

// ----- design/rfst_if.sv -----
// Valid/ready channel interfaces for commands, results and the register write port.
interface rfst_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 cmd;
   logic [rfst_pkg::POS_W-1:0]           range_start;
   logic [rfst_pkg::POS_W-1:0]           range_end;
   logic [rfst_pkg::QIDX_W-1:0]          query_index;

   modport source (output valid, cmd, range_start, range_end, query_index, input ready);
   modport sink   (input valid, cmd, range_start, range_end, query_index, output ready);
endinterface

interface rfst_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 bit_value;
   logic [rfst_pkg::TOTAL_W-1:0]         ones_total;

   modport source (output valid, bit_value, ones_total, input ready);
   modport sink   (input valid, bit_value, ones_total, output ready);
endinterface

interface rfst_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [rfst_pkg::POS_W-1:0]           data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- design/range_flip_segment_tree.sv -----
// Range flip segment tree: lazy bit row with range inversion, point query and ones count.
//
// Channels: req_bus takes one command item (flip a half-open range, or query one
// position); rsp_bus returns exactly one result item per command with the queried
// bit (0 for a flip) and the count of ones after the command; csr_bus writes
// n_used, which also clears every bit.
// The tree lives in one single-port-read memory of 2*T entries (T = SIZE rounded
// up to a power of two, at least 2), each holding a ones count and a pending-flip
// flag. Node reads are registered; a flip writes back each node that it inverts
// or rebuilds, while a query only reads. One command is worked on at a time;
// req_bus.ready is high only while idle. Results sit in an output register, so
// a new command is taken while an earlier result waits; a stalled receiver holds
// the finished result of the next command in the sequencer until the register
// frees.
// Reset, and every n_used write, starts a clearing pass over all 2*T entries,
// during which no command or register write is taken.
module range_flip_segment_tree #(
   parameter int SIZE = rfst_pkg::SIZE_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   rfst_req_if.sink      req_bus,
   rfst_rsp_if.source    rsp_bus,
   rfst_csr_if.sink      csr_bus
);
   import rfst_pkg::*;

   localparam int LOG  = (SIZE < 2) ? 1 : $clog2(SIZE);
   localparam int TREE = 1 << LOG;
   localparam int PW   = LOG + 1;          // position, holds TREE
   localparam int CW   = LOG + 1;          // ones count, holds TREE
   localparam int NW   = LOG + 1;          // node index below 2*TREE
   localparam int LW   = LOG + 2;          // loop bounds up to 2*TREE
   localparam int HW   = $clog2(LOG + 1);  // node height 0..LOG
   localparam int XW   = PW + POS_W;       // common width for compares
   localparam int MW   = CW + 1;           // memory word: pending flag, count

   // node memory
   logic [MW-1:0] mem [2*TREE];
   logic [MW-1:0] rd_data_ff;
   logic [NW-1:0] rd_addr;
   logic          wr_en;
   logic [NW-1:0] wr_addr;
   logic [MW-1:0] wr_data;

   state_type     state_ff, state_in;
   logic [PW-1:0] n_used_ff, n_used_in;
   logic [LW-1:0] l_ff, l_in, r_ff, r_in;
   logic [NW-1:0] l0_ff, l0_in, r1_ff, r1_in;
   logic [NW-1:0] node_ff, node_in;
   logic [HW-1:0] h_ff, h_in;
   logic          side_ff, side_in;
   logic          parity_ff, parity_in;
   logic          bit_ff, bit_in;
   logic [CW-1:0] left_ff, left_in, right_ff, right_in;
   logic [CW-1:0] total_ff, total_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_bit_ff, rsp_bit_in;
   logic [CW-1:0] rsp_total_ff, rsp_total_in;

   logic          req_fire, csr_fire, rsp_free;
   logic [XW-1:0] n_x, a_x, b_x, q_x, v_x;
   logic [PW-1:0] a_c, b_c;
   logic [LW-1:0] l_start, r_start;
   logic [CW-1:0] span, rd_cnt, sum, fix_cnt;
   logic          rd_pend;
   logic [NW-1:0] pl, pr, fx_node;
   logic [CW+TOTAL_W-1:0] tot_x;

   assign req_bus.ready = (state_ff == ST_IDLE) && !csr_bus.valid;
   assign csr_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.bit_value = rsp_bit_ff;
   assign tot_x             = {{TOTAL_W{1'b0}}, rsp_total_ff};
   assign rsp_bus.ones_total = tot_x[TOTAL_W-1:0];

   // clip the command fields to n_used
   assign n_x = {{POS_W{1'b0}}, n_used_ff};
   assign a_x = {{PW{1'b0}}, req_bus.range_start};
   assign b_x = {{PW{1'b0}}, req_bus.range_end};
   assign q_x = {{(XW-QIDX_W){1'b0}}, req_bus.query_index};
   assign v_x = {{PW{1'b0}}, csr_bus.data};
   assign a_c = (a_x > n_x) ? n_used_ff : a_x[PW-1:0];
   assign b_c = (b_x > n_x) ? n_used_ff : b_x[PW-1:0];
   assign l_start = LW'(TREE) + {1'b0, a_c};
   assign r_start = LW'(TREE) + {1'b0, b_c};

   // node fields
   assign rd_cnt  = rd_data_ff[CW-1:0];
   assign rd_pend = rd_data_ff[CW];
   assign span    = CW'(1) << h_ff;
   assign pl      = l0_ff >> h_ff;
   assign pr      = r1_ff >> h_ff;
   assign fx_node = side_ff ? pr : pl;
   assign sum     = left_ff + right_ff;
   assign fix_cnt = rd_pend ? (span - sum) : sum;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == '1) state_in = ST_IDLE;
         ST_IDLE: begin
            if (csr_fire) begin
               state_in = ST_CLEAR;
            end else if (req_fire) begin
               if (req_bus.cmd == CMD_FLIP) begin
                  state_in = (a_c < b_c) ? ST_STEP : ST_DONE;
               end else begin
                  state_in = (q_x < n_x) ? ST_Q_RD : ST_DONE;
               end
            end
         end
         ST_STEP: begin
            if (l_ff < r_ff) begin
               if (l_ff[0] || r_ff[0]) state_in = ST_AP_RD;
            end else begin
               state_in = ST_FX_L;
            end
         end
         ST_AP_RD: state_in = ST_AP_WR;
         ST_AP_WR: state_in = ST_STEP;
         ST_FX_L:  state_in = ST_FX_R;
         ST_FX_R:  state_in = ST_FX_S;
         ST_FX_S:  state_in = ST_FX_W;
         ST_FX_W: begin
            if (!side_ff && (pr != pl)) state_in = ST_FX_L;
            else if (h_ff == HW'(LOG))  state_in = ST_DONE;
            else                        state_in = ST_FX_L;
         end
         ST_Q_RD: state_in = ST_Q_CK;
         ST_Q_CK: state_in = (h_ff == '0) ? ST_DONE : ST_Q_RD;
         ST_DONE: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      n_used_in    = n_used_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      l0_in        = l0_ff;
      r1_in        = r1_ff;
      node_in      = node_ff;
      h_in         = h_ff;
      side_in      = side_ff;
      parity_in    = parity_ff;
      bit_in       = bit_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      total_in     = total_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_bit_in   = rsp_bit_ff;
      rsp_total_in = rsp_total_ff;
      rd_addr      = node_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = clr_ff;
            clr_in   = clr_ff + NW'(1);
            total_in = '0;
         end
         ST_IDLE: begin
            clr_in = '0;
            if (csr_fire) begin
               // clamp the register to 1..SIZE
               if (v_x == '0)             n_used_in = PW'(1);
               else if (v_x > XW'(SIZE))  n_used_in = PW'(SIZE);
               else                       n_used_in = v_x[PW-1:0];
            end else if (req_fire) begin
               bit_in    = 1'b0;
               parity_in = 1'b0;
               h_in      = '0;
               side_in   = 1'b0;
               l_in      = l_start;
               r_in      = r_start;
               l0_in     = l_start[NW-1:0];
               r1_in     = NW'(r_start - LW'(1));
               node_in   = NW'(TREE) + NW'(q_x[PW-1:0]);
               if (req_bus.cmd == CMD_QUERY) h_in = HW'(LOG);
            end
         end
         ST_STEP: begin
            // walk the covered nodes bottom up
            if (l_ff < r_ff) begin
               if (l_ff[0]) begin
                  node_in = l_ff[NW-1:0];
                  l_in    = l_ff + LW'(1);
               end else if (r_ff[0]) begin
                  node_in = NW'(r_ff - LW'(1));
                  r_in    = r_ff - LW'(1);
               end else begin
                  l_in = l_ff >> 1;
                  r_in = r_ff >> 1;
                  h_in = h_ff + HW'(1);
               end
            end else begin
               h_in    = HW'(1);
               side_in = 1'b0;
            end
         end
         ST_AP_RD: rd_addr = node_ff;
         ST_AP_WR: begin
            // invert the node and owe its children a flip
            wr_en   = 1'b1;
            wr_addr = node_ff;
            wr_data = {rd_pend ^ (h_ff != '0), span - rd_cnt};
            if (node_ff == NW'(1)) total_in = span - rd_cnt;
         end
         ST_FX_L: rd_addr = fx_node << 1;
         ST_FX_R: begin
            rd_addr = (fx_node << 1) | NW'(1);
            left_in = rd_cnt;
         end
         ST_FX_S: begin
            rd_addr  = fx_node;
            right_in = rd_cnt;
         end
         ST_FX_W: begin
            // rebuild the ancestor from its children
            wr_en   = 1'b1;
            wr_addr = fx_node;
            wr_data = {rd_pend, fix_cnt};
            if (fx_node == NW'(1)) total_in = fix_cnt;
            if (!side_ff && (pr != pl)) begin
               side_in = 1'b1;
            end else begin
               side_in = 1'b0;
               if (h_ff != HW'(LOG)) h_in = h_ff + HW'(1);
            end
         end
         ST_Q_RD: rd_addr = node_ff >> h_ff;
         ST_Q_CK: begin
            // gather pending flips down the path
            if (h_ff == '0) begin
               bit_in = rd_cnt[0] ^ parity_ff;
            end else begin
               parity_in = parity_ff ^ rd_pend;
               h_in      = h_ff - HW'(1);
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = bit_ff;
               rsp_total_in = total_ff;
            end
         end
         default: ;
      endcase
   end

   // node memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         n_used_ff    <= (N_USED_RESET > SIZE) ? PW'(SIZE) : PW'(N_USED_RESET);
         clr_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_used_ff    <= n_used_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      l_ff         <= l_in;
      r_ff         <= r_in;
      l0_ff        <= l0_in;
      r1_ff        <= r1_in;
      node_ff      <= node_in;
      h_ff         <= h_in;
      side_ff      <= side_in;
      parity_ff    <= parity_in;
      bit_ff       <= bit_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      rsp_bit_ff   <= rsp_bit_in;
      rsp_total_ff <= rsp_total_in;
   end

endmodule
